// ===== hw/rtl/audio_block_level_meter_macros.svh =====
// assertion helpers for the level meter
`ifndef AUDIO_BLOCK_LEVEL_METER_MACROS_SVH
`define AUDIO_BLOCK_LEVEL_METER_MACROS_SVH
`define ABLM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ABLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== hw/rtl/ablm_pkg.sv =====
package ablm_pkg;
   localparam int SAMPLE_W = 16;
   localparam int OUT_W = 16;
   localparam int COUNT_W = 13;
   localparam int ANGLE_W = 16;
   localparam int ASUM_W = 28;
   localparam int CORDIC_STEPS = 14;
   localparam int CORDIC_W = 28;
   localparam int CORDIC_PRESHIFT = 8;
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 16'sd12868;
   localparam logic signed [ANGLE_W-1:0] PI_Q13 = 16'sd25736;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] cur;
      logic signed [SAMPLE_W-1:0] prev;
      logic                       pair;
      logic                       keep;
      logic                       last;
   } front_item_type;

   function automatic logic signed [ANGLE_W-1:0] arctan_q13(input logic [3:0] i);
      logic signed [ANGLE_W-1:0] r;
      case (i)
         4'd0: r = 16'sd6434;
         4'd1: r = 16'sd3798;
         4'd2: r = 16'sd2007;
         4'd3: r = 16'sd1019;
         4'd4: r = 16'sd511;
         4'd5: r = 16'sd256;
         4'd6: r = 16'sd128;
         4'd7: r = 16'sd64;
         4'd8: r = 16'sd32;
         4'd9: r = 16'sd16;
         4'd10: r = 16'sd8;
         4'd11: r = 16'sd4;
         4'd12: r = 16'sd2;
         4'd13: r = 16'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage

// ===== hw/rtl/ablm_front.sv =====
module ablm_front #(
   parameter int MAX_LEN = 4096,
   parameter int CNT_W = 17
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [ablm_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                  req_last,
   output logic                                  fq_push,
   input  logic                                  fq_full,
   output ablm_pkg::front_item_type              fq_item
);
   logic [CNT_W-1:0] count_ff, count_in;
   logic signed [ablm_pkg::SAMPLE_W-1:0] prev_ff, prev_in;
   logic keep;
   logic fire;

   assign req_full = fq_full;
   assign fire = req_push && !fq_full;
   assign keep = count_ff < CNT_W'(MAX_LEN);
   assign fq_push = fire;
   assign fq_item.cur = req_sample;
   assign fq_item.prev = prev_ff;
   assign fq_item.pair = keep && (count_ff != '0);
   assign fq_item.keep = keep;
   assign fq_item.last = req_last;

   always_comb begin
      count_in = count_ff;
      prev_in = prev_ff;
      if (fire) begin
         if (keep) begin
            count_in = count_ff + 1'b1;
            prev_in = req_sample;
         end
         if (req_last) begin
            count_in = '0;
            prev_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         prev_ff <= '0;
      end else begin
         count_ff <= count_in;
         prev_ff <= prev_in;
      end
   end
endmodule

// ===== hw/rtl/ablm_queue.sv =====
module ablm_queue #(
   parameter int W = 34
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  logic [W-1:0] wdata,
   input  logic         pop,
   output logic         empty,
   output logic [W-1:0] rdata
);
   logic [W-1:0] mem_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   n_ff;

   assign full = n_ff == 2'd2;
   assign empty = n_ff == 2'd0;
   assign rdata = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wp_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         n_ff <= '0;
      end else begin
         if (push && !full) wp_ff <= !wp_ff;
         if (pop && !empty) rp_ff <= !rp_ff;
         n_ff <= n_ff + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
      end
   end
endmodule

// ===== hw/rtl/ablm_back.sv =====
module ablm_back #(
   parameter int MAX_LEN = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fq_empty,
   output logic                             fq_pop,
   input  ablm_pkg::front_item_type         fq_item,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [ablm_pkg::OUT_W-1:0]       rsp_level,
   output logic [ablm_pkg::OUT_W-1:0]       rsp_mean_abs,
   output logic signed [ablm_pkg::OUT_W-1:0] rsp_mean_phase,
   output logic [ablm_pkg::COUNT_W-1:0]     rsp_sample_count,
   output logic                             rsp_truncated
);
   localparam int CW = ablm_pkg::CORDIC_W;
   localparam int AW = ablm_pkg::ANGLE_W;
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int SQ_W = 32 + CNT_W;
   localparam int MG_W = 16 + CNT_W;
   localparam int AS_W = 16 + CNT_W;
   localparam int DIV_W = SQ_W;
   localparam int KW = $clog2(DIV_W + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CORD = 4'd1;
   localparam logic [3:0] S_ACC  = 4'd2;
   localparam logic [3:0] S_DSQ  = 4'd3;
   localparam logic [3:0] S_DMG  = 4'd4;
   localparam logic [3:0] S_DPH  = 4'd5;
   localparam logic [3:0] S_SQRT = 4'd6;
   localparam logic [3:0] S_OUT  = 4'd7;
   localparam logic [3:0] S_MUL  = 4'd8;

   logic [3:0] st_ff;
   logic [SQ_W-1:0] sq_ff;
   logic [MG_W-1:0] mg_ff;
   logic signed [AS_W-1:0] as_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic ovf_ff;
   logic last_ff;
   logic [15:0] mag_ff;
   logic [31:0] msq_ff;
   logic signed [CW-1:0] x_ff, y_ff;
   logic signed [AW+1:0] z_ff;
   logic [3:0] i_ff;
   logic cord_ff;
   logic [DIV_W-1:0] num_ff, quo_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [CNT_W-1:0] den_ff;
   logic [KW-1:0] k_ff;
   logic neg_ff;
   logic [SQ_W-1:0] sv_ff, sroot_ff, sbit_ff;
   logic [15:0] lvl_ff, mab_ff, ph_ff;
   logic has_ff;

   logic signed [CW-1:0] dx, dy;
   logic signed [AW+1:0] za;
   logic [DIV_W:0] rtry;
   logic [SQ_W-1:0] stry;
   logic signed [16:0] cs, ps;

   assign dx = y_ff >>> i_ff;
   assign dy = x_ff >>> i_ff;
   assign za = (AW+2)'(ablm_pkg::arctan_q13(i_ff));
   assign rtry = {rem_ff, num_ff[DIV_W-1]} - (DIV_W+1)'(den_ff);
   assign stry = sroot_ff + sbit_ff;
   assign cs = 17'(fq_item.cur);
   assign ps = 17'(fq_item.prev);

   assign fq_pop = (st_ff == S_IDLE) && !fq_empty;
   assign rsp_empty = st_ff != S_OUT;
   assign rsp_level = lvl_ff;
   assign rsp_mean_abs = mab_ff;
   assign rsp_mean_phase = ph_ff;
   assign rsp_sample_count = ablm_pkg::COUNT_W'(cnt_ff);
   assign rsp_truncated = ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         sq_ff <= '0; mg_ff <= '0; as_ff <= '0; cnt_ff <= '0; ovf_ff <= 1'b0;
      end else begin
         unique case (st_ff)
            S_IDLE: if (!fq_empty) begin
               last_ff <= fq_item.last;
               mag_ff <= cs[16] ? 16'(-cs) : 16'(cs);
               cord_ff <= 1'b0;
               z_ff <= '0;
               i_ff <= '0;
               if (!fq_item.keep) begin
                  ovf_ff <= 1'b1;
                  st_ff <= fq_item.last ? S_DSQ : S_IDLE;
                  num_ff <= DIV_W'(sq_ff); den_ff <= cnt_ff;
                  rem_ff <= '0; quo_ff <= '0; k_ff <= '0; neg_ff <= 1'b0;
               end else begin
                  st_ff <= S_MUL;
                  if (fq_item.pair) begin
                     if (cs == 0) z_ff <= (ps < 0) ? (AW+2)'(ablm_pkg::PI_Q13) : '0;
                     else if (ps == 0)
                        z_ff <= (cs > 0) ? (AW+2)'(ablm_pkg::HALF_PI_Q13)
                                         : -(AW+2)'(ablm_pkg::HALF_PI_Q13);
                     else begin
                        cord_ff <= 1'b1;
                        if (ps < 0 && cs > 0) begin
                           x_ff <= CW'(cs) <<< ablm_pkg::CORDIC_PRESHIFT;
                           y_ff <= CW'(-ps) <<< ablm_pkg::CORDIC_PRESHIFT;
                           z_ff <= (AW+2)'(ablm_pkg::HALF_PI_Q13);
                        end else if (ps < 0) begin
                           x_ff <= CW'(-cs) <<< ablm_pkg::CORDIC_PRESHIFT;
                           y_ff <= CW'(ps) <<< ablm_pkg::CORDIC_PRESHIFT;
                           z_ff <= -(AW+2)'(ablm_pkg::HALF_PI_Q13);
                        end else begin
                           x_ff <= CW'(ps) <<< ablm_pkg::CORDIC_PRESHIFT;
                           y_ff <= CW'(cs) <<< ablm_pkg::CORDIC_PRESHIFT;
                        end
                     end
                  end
               end
            end
            S_MUL: begin
               msq_ff <= 32'(mag_ff) * 32'(mag_ff);
               st_ff <= cord_ff ? S_CORD : S_ACC;
            end
            S_CORD: begin
               if (y_ff >= 0) begin
                  x_ff <= x_ff + dx; y_ff <= y_ff - dy; z_ff <= z_ff + za;
               end else begin
                  x_ff <= x_ff - dx; y_ff <= y_ff + dy; z_ff <= z_ff - za;
               end
               i_ff <= i_ff + 1'b1;
               if (i_ff == 4'(ablm_pkg::CORDIC_STEPS - 1)) st_ff <= S_ACC;
            end
            S_ACC: begin
               sq_ff <= sq_ff + SQ_W'(msq_ff);
               mg_ff <= mg_ff + MG_W'(mag_ff);
               if (z_ff > (AW+2)'(ablm_pkg::PI_Q13))
                  as_ff <= as_ff + AS_W'(ablm_pkg::PI_Q13);
               else if (z_ff < -(AW+2)'(ablm_pkg::PI_Q13))
                  as_ff <= as_ff - AS_W'(ablm_pkg::PI_Q13);
               else as_ff <= as_ff + AS_W'(z_ff);
               cnt_ff <= cnt_ff + 1'b1;
               num_ff <= DIV_W'(sq_ff + SQ_W'(msq_ff));
               den_ff <= cnt_ff + 1'b1;
               rem_ff <= '0; quo_ff <= '0; k_ff <= '0; neg_ff <= 1'b0;
               st_ff <= last_ff ? S_DSQ : S_IDLE;
            end
            S_DSQ, S_DMG, S_DPH: begin
               num_ff <= num_ff << 1;
               if (!rtry[DIV_W]) begin
                  rem_ff <= rtry[DIV_W-1:0];
                  quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[DIV_W-2:0], num_ff[DIV_W-1]};
                  quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
               end
               k_ff <= k_ff + 1'b1;
               if (k_ff == KW'(DIV_W - 1)) begin
                  k_ff <= '0; rem_ff <= '0; quo_ff <= '0;
                  if (st_ff == S_DSQ) begin
                     sv_ff <= !rtry[DIV_W] ? {quo_ff[DIV_W-2:0], 1'b1}
                                          : {quo_ff[DIV_W-2:0], 1'b0};
                     num_ff <= DIV_W'(mg_ff);
                     st_ff <= S_DMG;
                  end else if (st_ff == S_DMG) begin
                     mab_ff <= !rtry[DIV_W] ? {quo_ff[14:0], 1'b1} : {quo_ff[14:0], 1'b0};
                     neg_ff <= as_ff < 0;
                     num_ff <= DIV_W'(as_ff < 0 ? -as_ff : as_ff);
                     den_ff <= cnt_ff - 1'b1;
                     has_ff <= cnt_ff > 1;
                     st_ff <= S_DPH;
                  end else begin
                     ph_ff <= !has_ff ? '0 :
                        (neg_ff ? -(!rtry[DIV_W] ? {quo_ff[14:0], 1'b1} : {quo_ff[14:0], 1'b0})
                                :  (!rtry[DIV_W] ? {quo_ff[14:0], 1'b1} : {quo_ff[14:0], 1'b0}));
                     sroot_ff <= '0;
                     sbit_ff <= SQ_W'(1) << (2 * ((SQ_W - 1) / 2));
                     st_ff <= S_SQRT;
                  end
               end
            end
            S_SQRT: begin
               if (sbit_ff == '0) begin
                  lvl_ff <= 16'(sroot_ff);
                  st_ff <= S_OUT;
               end else begin
                  if (sv_ff >= stry) begin
                     sv_ff <= sv_ff - stry;
                     sroot_ff <= (sroot_ff >> 1) + sbit_ff;
                  end else sroot_ff <= sroot_ff >> 1;
                  sbit_ff <= sbit_ff >> 2;
               end
            end
            S_OUT: if (rsp_pop) begin
               st_ff <= S_IDLE;
               sq_ff <= '0; mg_ff <= '0; as_ff <= '0; cnt_ff <= '0; ovf_ff <= 1'b0;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== hw/rtl/audio_block_level_meter.sv =====
// audio_block_level_meter: per-buffer level meter for Q1.15 audio samples.
// input channel: req_push / req_full with req_sample and req_last; a
//   transaction happens when req_push is high and req_full is low.
// result channel: rsp_empty / rsp_pop; the result for a buffer appears
//   after the sample flagged last and leaves when rsp_pop is high while
//   rsp_empty is low.
// per sample in the back end: pick-up, a multiply state, a 14-step atan2
//   cordic (only for pairs with both samples nonzero), an accumulate state.
// a two-entry queue between front and back lets the next samples be taken
//   while the back end is busy.
// end of buffer: three serial divisions of clog2(MAX_LEN+1)+32 bits
//   (one quotient bit per cycle) plus an integer square root.
// samples past MAX_LEN are dropped and flagged in rsp_truncated.
// reset clears all sums; the block holds the result while rsp_pop is low
//   and stops taking samples once its queue fills.
module audio_block_level_meter #(
   parameter int MAX_LEN = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic signed [15:0]                req_sample,
   input  logic                              req_last,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [15:0]                       rsp_level,
   output logic [15:0]                       rsp_mean_abs,
   output logic signed [15:0]                rsp_mean_phase,
   output logic [12:0]                       rsp_sample_count,
   output logic                              rsp_truncated
);
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int IW = $bits(ablm_pkg::front_item_type);

   logic fq_push, fq_full, fq_pop, fq_empty;
   ablm_pkg::front_item_type f_item, b_item;

   ablm_front #(.MAX_LEN(MAX_LEN), .CNT_W(CNT_W)) u_front (
      .clock, .reset, .req_push, .req_full, .req_sample, .req_last,
      .fq_push, .fq_full, .fq_item(f_item)
   );

   ablm_queue #(.W(IW)) u_queue (
      .clock, .reset, .push(fq_push), .full(fq_full), .wdata(f_item),
      .pop(fq_pop), .empty(fq_empty), .rdata(b_item)
   );

   ablm_back #(.MAX_LEN(MAX_LEN)) u_back (
      .clock, .reset, .fq_empty, .fq_pop, .fq_item(b_item),
      .rsp_empty, .rsp_pop, .rsp_level, .rsp_mean_abs, .rsp_mean_phase,
      .rsp_sample_count, .rsp_truncated
   );
endmodule

// ===== hw/rtl/ablm_checker.sv =====
`include "audio_block_level_meter_macros.svh"
module ablm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [15:0] rsp_level,
   input logic [12:0] rsp_sample_count
);
   `ABLM_ASSERT_NEXT(a_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_level))
   `ABLM_ASSERT_IMPL(a_count, clock, reset, !rsp_empty, rsp_sample_count != 13'd0)
   `ABLM_ASSERT_IMPL(a_range, clock, reset, !rsp_empty, rsp_level <= 16'd32768)
   `ABLM_ASSERT_NEXT(a_rst, clock, 1'b0, reset, rsp_empty && !req_full)
endmodule

bind audio_block_level_meter ablm_checker u_ablm_checker (
   .clock, .reset, .req_full, .rsp_empty, .rsp_pop, .rsp_level, .rsp_sample_count
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   localparam int BUFFER_LIMIT = 4096;
   localparam int IDLE_LIMIT = 5000;
   localparam int RANDOM_ITEMS = 700;

   typedef struct {
      logic [15:0] level;
      logic [15:0] mean_abs;
      logic [15:0] mean_phase;
      logic [12:0] sample_count;
      logic        truncated;
   } meter_reading_type;

   class level_scoreboard;
      meter_reading_type pending_readings[$];
      int errors;
      longint unsigned square_acc;
      longint unsigned magnitude_acc;
      longint angle_acc;
      int taken;
      longint prev_sample;
      bit dropped;
      longint atan_step[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};

      function new();
         errors = 0;
         clear_buffer();
      endfunction

      function void clear_buffer();
         square_acc = 0;
         magnitude_acc = 0;
         angle_acc = 0;
         taken = 0;
         prev_sample = 0;
         dropped = 0;
      endfunction

      function longint pair_angle(longint y, longint x);
         longint z, t, dx, dy;
         z = 0;
         if (y == 0) return (x < 0) ? 25736 : 0;
         if (x == 0) return (y > 0) ? 12868 : -12868;
         if (x < 0) begin
            if (y > 0) begin
               t = x; x = y; y = -t; z = 12868;
            end else begin
               t = x; x = -y; y = t; z = -12868;
            end
         end
         x = x * 256;
         y = y * 256;
         for (int i = 0; i < 14; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; z += atan_step[i];
            end else begin
               x -= dx; y += dy; z -= atan_step[i];
            end
         end
         if (z > 25736) z = 25736;
         if (z < -25736) z = -25736;
         return z;
      endfunction

      function longint unsigned isqrt(longint unsigned v);
         longint unsigned root, b;
         root = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= root + b) begin
               v -= root + b;
               root = (root >> 1) + b;
            end else begin
               root >>= 1;
            end
            b >>= 2;
         end
         return root;
      endfunction

      function void note_sample(logic signed [15:0] sample, logic last);
         longint s, mag, phase;
         meter_reading_type r;
         s = sample;
         if (taken < BUFFER_LIMIT) begin
            mag = (s < 0) ? -s : s;
            square_acc += mag * mag;
            magnitude_acc += mag;
            if (taken > 0) angle_acc += pair_angle(s, prev_sample);
            prev_sample = s;
            taken++;
         end else begin
            dropped = 1;
         end
         if (!last) return;
         phase = 0;
         if (taken > 1) phase = angle_acc / longint'(taken - 1);
         r.level = 16'(isqrt(square_acc / longint'(taken)));
         r.mean_abs = 16'(magnitude_acc / longint'(taken));
         r.mean_phase = phase[15:0];
         r.sample_count = 13'(taken);
         r.truncated = dropped;
         pending_readings = {pending_readings, r};
         clear_buffer();
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_result(meter_reading_type got);
         meter_reading_type want;
         if (pending_readings.size() == 0) begin
            report("result with no transaction pending");
            return;
         end
         want = pending_readings.pop_front();
         if (got.level !== want.level)
            report($sformatf("level %0d, want %0d", got.level, want.level));
         if (got.mean_abs !== want.mean_abs)
            report($sformatf("mean_abs %0d, want %0d", got.mean_abs, want.mean_abs));
         if (got.mean_phase !== want.mean_phase)
            report($sformatf("mean_phase %0d, want %0d",
               $signed(got.mean_phase), $signed(want.mean_phase)));
         if (got.sample_count !== want.sample_count)
            report($sformatf("sample_count %0d, want %0d",
               got.sample_count, want.sample_count));
         if (got.truncated !== want.truncated)
            report($sformatf("truncated %0b, want %0b", got.truncated, want.truncated));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_push = 0;
   logic req_full;
   logic signed [15:0] req_sample = 0;
   logic req_last = 0;
   logic rsp_empty;
   logic rsp_pop = 0;
   logic [15:0] rsp_level;
   logic [15:0] rsp_mean_abs;
   logic signed [15:0] rsp_mean_phase;
   logic [12:0] rsp_sample_count;
   logic rsp_truncated;

   level_scoreboard sb = new();
   bit burst = 0;
   int idle_cycles = 0;

   audio_block_level_meter uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_sample(req_sample), .req_last(req_last),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_level(rsp_level), .rsp_mean_abs(rsp_mean_abs),
      .rsp_mean_phase(rsp_mean_phase), .rsp_sample_count(rsp_sample_count),
      .rsp_truncated(rsp_truncated)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function int pick_gap();
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(20, 200);
   endfunction

   function logic signed [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'(int'($urandom_range(0, 15)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   task send_sample(logic signed [15:0] sample, logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_push = 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_push = 1;
      req_sample = sample;
      req_last = last;
      forever begin
         @(posedge clock);
         if (!req_full) break;
      end
      sb.note_sample(sample, last);
   endtask

   task send_buffer(int len);
      for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
   endtask

   task drain_results();
      int gap;
      meter_reading_type got;
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            @(negedge clock) rsp_pop = 0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock) rsp_pop = 1;
         forever begin
            @(posedge clock);
            if (!rsp_empty) break;
         end
         got.level = rsp_level;
         got.mean_abs = rsp_mean_abs;
         got.mean_phase = rsp_mean_phase;
         got.sample_count = rsp_sample_count;
         got.truncated = rsp_truncated;
         sb.check_result(got);
      end
   endtask

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int sent, len;
      repeat (3) @(posedge clock);
      @(negedge clock) reset = 0;
      fork
         drain_results();
      join_none
      // directed: extremes, axes, all quadrants, single-sample buffers
      send_sample(16'sh7fff, 1);
      send_sample(16'sh8000, 1);
      send_sample(16'sh0000, 0);
      send_sample(16'sh0000, 1);
      send_sample(16'sd100, 0);
      send_sample(16'sd0, 0);
      send_sample(-16'sd100, 0);
      send_sample(16'sd0, 0);
      send_sample(16'sd50, 0);
      send_sample(16'sd0, 0);
      send_sample(-16'sd50, 1);
      send_sample(16'sh8000, 0);
      send_sample(16'sh7fff, 0);
      send_sample(16'sh8000, 0);
      send_sample(-16'sd1, 0);
      send_sample(16'sd1, 0);
      send_sample(16'sh7fff, 0);
      send_sample(16'sh7fff, 1);
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = ($urandom_range(0, 4) == 0);
         len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 24);
         send_buffer(len);
         sent += len;
      end
      @(negedge clock) req_push = 0;
      burst = 0;
      while (sb.pending_readings.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.errors == 0 && sb.pending_readings.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
